/* rtl/path_lookahead_follower_core_macros.svh */
// Assertion macros used by the checker file of the path follower.
`ifndef PATH_LOOKAHEAD_FOLLOWER_CORE_MACROS_SVH
`define PATH_LOOKAHEAD_FOLLOWER_CORE_MACROS_SVH

// same-cycle implication, ignored while reset is held
`define PLF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("plf assertion failed");

// next-cycle implication, ignored while reset is held
`define PLF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("plf assertion failed");

// next-cycle implication that also holds through reset
`define PLF_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("plf assertion failed");

`endif

/* rtl/plf_pkg.sv */
// Package: types and constants of the path lookahead follower.
`default_nettype none

package plf_pkg;

    localparam int IDX_BITS       = 8;
    localparam int LEN_BITS       = IDX_BITS + 1;
    localparam int LOOK_BITS      = 8;
    localparam int GAIN_BITS      = 16;
    localparam int VEL_BITS       = 24;
    localparam int VEL_SHIFT      = 8;
    localparam int VEL_MAX        = 2**(VEL_BITS - 1) - 1;
    localparam int VEL_MIN        = -(2**(VEL_BITS - 1));
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd256;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOOKAHEAD  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPEED_GAIN = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_TGT   = 6'b000100,
        S_FETCH = 6'b001000,
        S_MUL   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

endpackage

`default_nettype wire

/* rtl/path_lookahead_follower_core.sv */
// Top level: path store with nearest-point search and lookahead velocity command.
//
// Input channel (i_in_valid / o_in_stall) carries load and query items. A load
// (cmd 0) writes one path point; loads may come back to back. A load with
// last_point set makes the path point_index + 1 points long. A query (cmd 1)
// stalls the input channel while it runs. The path memory has one read port,
// so the scan reads one point per cycle; an empty path skips the scan.
// The scan is pipelined (read, difference, square, compare), then the target
// point is read back and its offset from the pose is scaled by the gain.
// The result sits in an output register (o_out_valid / i_out_stall). While the
// receiver stalls, loads are still taken; a finished query waits in its last
// step until the output register is free.
// Configuration writes (i_cfg_we) are taken in any cycle and must come only
// while the block is idle. Reset clears the path length, lookahead, state and
// output valid, sets the gain to GAIN_RESET; the point memory is not cleared.
`default_nettype none

module path_lookahead_follower_core #(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 20
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_cmd,
    input  logic [plf_pkg::IDX_BITS-1:0]          i_point_index,
    input  logic signed [COORD_BITS-1:0]          i_coord_x,
    input  logic signed [COORD_BITS-1:0]          i_coord_y,
    input  logic                                  i_last_point,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [plf_pkg::VEL_BITS-1:0]   o_vel_x,
    output logic signed [plf_pkg::VEL_BITS-1:0]   o_vel_y,
    output logic signed [COORD_BITS-1:0]          o_target_x,
    output logic signed [COORD_BITS-1:0]          o_target_y,
    output logic [plf_pkg::IDX_BITS-1:0]          o_target_index,
    output logic                                  o_no_path,
    input  logic                                  i_cfg_we,
    input  logic [plf_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [plf_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);

    import plf_pkg::*;

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CB  = COORD_BITS;
    localparam int DW  = CB + 1;
    localparam int SQW = 2 * CB + 1;
    localparam int SW  = SQW + 1;
    localparam int PW  = DW + GAIN_BITS + 1;

    function automatic logic [VEL_BITS-1:0] f_sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] q;
        logic [VEL_BITS-1:0]  res;
        q = p >>> VEL_SHIFT;
        if (q > PW'(VEL_MAX)) begin
            res = VEL_BITS'(VEL_MAX);
        end else if (q < PW'(VEL_MIN)) begin
            res = VEL_BITS'(VEL_MIN);
        end else begin
            res = q[VEL_BITS-1:0];
        end
        return res;
    endfunction

    t_state r_state, n_state;

    logic [LOOK_BITS-1:0] r_look;
    logic [GAIN_BITS-1:0] r_gain;
    logic [LEN_BITS-1:0]  r_path_len;
    logic [LEN_BITS-1:0]  r_cnt;
    logic                 r_v1, r_v2, r_v3;
    logic                 r_have_best;
    logic                 r_empty;
    logic                 r_out_valid;

    logic signed [CB-1:0] r_px, r_py;
    logic [IDX_BITS-1:0]  r_i1, r_i2, r_i3;
    logic signed [DW-1:0] r_dx, r_dy;
    logic [SQW-1:0]       r_sqx, r_sqy;
    logic [SW-1:0]        r_best_d;
    logic [IDX_BITS-1:0]  r_best_idx;
    logic [IDX_BITS-1:0]  r_tgt;
    logic signed [CB-1:0] r_tx, r_ty;
    logic signed [PW-1:0] r_prod_x, r_prod_y;

    logic signed [VEL_BITS-1:0] r_vel_x, r_vel_y;
    logic signed [CB-1:0]       r_out_tx, r_out_ty;
    logic [IDX_BITS-1:0]        r_out_idx;
    logic                       r_out_np;

    logic                  in_acc, out_acc, out_free;
    logic                  do_load, do_query, issue, pipe_busy, take_best, done_fire;
    logic [AW-1:0]         raddr;
    logic [2*CB-1:0]       rdata;
    logic signed [CB-1:0]  rd_x, rd_y;
    logic signed [DW-1:0]  diff_x, diff_y;
    logic signed [2*DW-1:0] sq_x, sq_y;
    logic [SW-1:0]         dsum;
    logic [LEN_BITS-1:0]   look_sum, len_m1, tgt_full;
    logic [IDX_BITS-1:0]   tgt_sel;
    logic signed [PW-1:0]  prod_x, prod_y;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_out_valid && !i_out_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign do_load    = in_acc && (i_cmd == CMD_LOAD) && (int'(i_point_index) < MAX_POINTS);
    assign do_query   = in_acc && (i_cmd == CMD_QUERY);
    assign issue      = (r_state == S_SCAN) && (r_cnt != r_path_len);
    assign pipe_busy  = issue || r_v1 || r_v2 || r_v3;
    assign done_fire  = (r_state == S_DONE) && out_free;

    assign look_sum = {1'b0, r_best_idx} + {1'b0, r_look};
    assign len_m1   = r_path_len - LEN_BITS'(1);
    assign tgt_full = (look_sum > len_m1) ? len_m1 : look_sum;
    assign tgt_sel  = tgt_full[IDX_BITS-1:0];

    assign raddr = (r_state == S_TGT) ? AW'(tgt_sel) : AW'(r_cnt);

    plf_ram #(
        .WIDTH (2 * CB),
        .DEPTH (MAX_POINTS)
    ) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (do_load),
        .i_waddr (AW'(i_point_index)),
        .i_wdata ({i_coord_x, i_coord_y}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_x   = rdata[2*CB-1:CB];
    assign rd_y   = rdata[CB-1:0];
    assign diff_x = $signed({rd_x[CB-1], rd_x}) - $signed({r_px[CB-1], r_px});
    assign diff_y = $signed({rd_y[CB-1], rd_y}) - $signed({r_py[CB-1], r_py});
    assign sq_x   = r_dx * r_dx;
    assign sq_y   = r_dy * r_dy;
    assign dsum   = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign take_best = r_v3 && (!r_have_best || (dsum < r_best_d));
    assign prod_x = r_dx * $signed({1'b0, r_gain});
    assign prod_y = r_dy * $signed({1'b0, r_gain});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (do_query) begin
                    n_state = (r_path_len == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!pipe_busy) begin
                    n_state = S_TGT;
                end
            end
            S_TGT:   n_state = S_FETCH;
            S_FETCH: n_state = S_MUL;
            S_MUL:   n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_look      <= '0;
            r_gain      <= GAIN_RESET;
            r_path_len  <= '0;
            r_cnt       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_have_best <= 1'b0;
            r_empty     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LOOKAHEAD:  r_look <= i_cfg_data[LOOK_BITS-1:0];
                    CFG_SPEED_GAIN: r_gain <= i_cfg_data[GAIN_BITS-1:0];
                endcase
            end
            if (do_load && i_last_point) begin
                r_path_len <= {1'b0, i_point_index} + LEN_BITS'(1);
            end
            if (do_query) begin
                r_cnt       <= '0;
                r_have_best <= 1'b0;
                r_empty     <= (r_path_len == '0);
            end else begin
                if (issue) begin
                    r_cnt <= r_cnt + LEN_BITS'(1);
                end
                if (take_best) begin
                    r_have_best <= 1'b1;
                end
            end
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_query) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
        r_i1 <= r_cnt[IDX_BITS-1:0];
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        if (r_v1 || (r_state == S_FETCH)) begin
            r_dx <= diff_x;
            r_dy <= diff_y;
        end
        r_sqx <= sq_x[SQW-1:0];
        r_sqy <= sq_y[SQW-1:0];
        if (take_best) begin
            r_best_d   <= dsum;
            r_best_idx <= r_i3;
        end
        if (r_state == S_TGT) begin
            r_tgt <= tgt_sel;
        end
        if (r_state == S_FETCH) begin
            r_tx <= rd_x;
            r_ty <= rd_y;
        end
        if (r_state == S_MUL) begin
            r_prod_x <= prod_x;
            r_prod_y <= prod_y;
        end
        if (done_fire) begin
            if (r_empty) begin
                r_vel_x   <= '0;
                r_vel_y   <= '0;
                r_out_tx  <= '0;
                r_out_ty  <= '0;
                r_out_idx <= '0;
                r_out_np  <= 1'b1;
            end else begin
                r_vel_x   <= f_sat(r_prod_x);
                r_vel_y   <= f_sat(r_prod_y);
                r_out_tx  <= r_tx;
                r_out_ty  <= r_ty;
                r_out_idx <= r_tgt;
                r_out_np  <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_vel_x        = r_vel_x;
    assign o_vel_y        = r_vel_y;
    assign o_target_x     = r_out_tx;
    assign o_target_y     = r_out_ty;
    assign o_target_index = r_out_idx;
    assign o_no_path      = r_out_np;

endmodule

`default_nettype wire

/* rtl/plf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module plf_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/plf_checker.sv */
// Port-level assertion checker of the path follower, bound to the top level.
`default_nettype none
`include "path_lookahead_follower_core_macros.svh"

module plf_checker #(
    parameter int COORD_BITS = 20
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                i_cmd,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [plf_pkg::VEL_BITS-1:0] o_vel_x,
    input logic signed [plf_pkg::VEL_BITS-1:0] o_vel_y,
    input logic signed [COORD_BITS-1:0]        o_target_x,
    input logic signed [COORD_BITS-1:0]        o_target_y,
    input logic [plf_pkg::IDX_BITS-1:0]        o_target_index,
    input logic                                o_no_path
);

    import plf_pkg::*;

    logic query_acc;
    assign query_acc = i_in_valid && !o_in_stall && (i_cmd == CMD_QUERY);

    `PLF_ASSERT_NEXT_ALWAYS(a_reset_clears_out, !i_rst_n, !o_out_valid)
    `PLF_ASSERT_NEXT(a_query_busy, query_acc, o_in_stall)
    `PLF_ASSERT_NOW(a_result_after_busy, $rose(o_out_valid), $past(o_in_stall))
    `PLF_ASSERT_NOW(a_no_path_zero, o_out_valid && o_no_path, (o_vel_x == 0) && (o_vel_y == 0) && (o_target_x == 0) && (o_target_y == 0) && (o_target_index == 0))
    `PLF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_target_index) && $stable(o_vel_x) && $stable(o_no_path))

endmodule

bind path_lookahead_follower_core plf_checker #(.COORD_BITS(COORD_BITS)) u_plf_checker (.*);

`default_nettype wire

/* verif/tb_path_lookahead_follower_core.sv */
// Self-checking testbench for the path lookahead follower: random path loads and pose queries.
`timescale 1ns / 100ps

module tb_path_lookahead_follower_core;
    import plf_pkg::*;

    localparam int     COORD_BITS    = 20;
    localparam int     MAX_POINTS    = 256;
    localparam int     ITEM_TARGET   = 2000;
    localparam int     SETTLE_CYCLES = MAX_POINTS + 16;
    localparam int     CYCLE_LIMIT   = 2_000_000;
    localparam int     MAX_REPORTS   = 100;
    localparam longint COORD_MAX     = 2**(COORD_BITS - 1) - 1;
    localparam longint COORD_MIN     = -(2**(COORD_BITS - 1));

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic                cmd;
        logic [IDX_BITS-1:0] index;
        t_coord              x;
        t_coord              y;
        logic                last;
    } t_path_item;

    typedef struct packed {
        logic signed [VEL_BITS-1:0] vel_x;
        logic signed [VEL_BITS-1:0] vel_y;
        t_coord                     target_x;
        t_coord                     target_y;
        logic [IDX_BITS-1:0]        target_index;
        logic                       no_path;
    } t_target_cmd;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_cmd = 1'b0;
    logic [IDX_BITS-1:0]        i_point_index = '0;
    t_coord                     i_coord_x = '0;
    t_coord                     i_coord_y = '0;
    logic                       i_last_point = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [VEL_BITS-1:0] o_vel_x;
    logic signed [VEL_BITS-1:0] o_vel_y;
    t_coord                     o_target_x;
    t_coord                     o_target_y;
    logic [IDX_BITS-1:0]        o_target_index;
    logic                       o_no_path;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   i_cfg_data = '0;

    // predictor state
    t_coord                path_store_x [MAX_POINTS];
    t_coord                path_store_y [MAX_POINTS];
    int                    path_len_now = 0;
    logic [LOOK_BITS-1:0]  lookahead_now = '0;
    logic [GAIN_BITS-1:0]  gain_now = GAIN_RESET;

    // stimulus side view of the path
    bit                    loaded [MAX_POINTS];
    t_coord                plan_x [MAX_POINTS];
    t_coord                plan_y [MAX_POINTS];
    int                    planned_len = 0;
    int                    stimulus_items = 0;

    t_path_item            pending_items [$];
    t_target_cmd           expected_commands [$];
    t_path_item            current_item;
    t_target_cmd           next_expected;

    int                    idle_pct = 0;
    int                    gap_left = 0;
    int                    stall_left = 0;
    int                    mismatch_count = 0;
    int                    cycle_count = 0;

    path_lookahead_follower_core #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_point_index  (i_point_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_last_point   (i_last_point),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_vel_x        (o_vel_x),
        .o_vel_y        (o_vel_y),
        .o_target_x     (o_target_x),
        .o_target_y     (o_target_y),
        .o_target_index (o_target_index),
        .o_no_path      (o_no_path),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint scaled_velocity(input longint offset);
        longint v;
        v = (offset * longint'(gain_now)) >>> VEL_SHIFT;  // floor toward minus infinity
        if (v > VEL_MAX) v = VEL_MAX;
        if (v < VEL_MIN) v = VEL_MIN;
        return v;
    endfunction

    task automatic predict_target_command(input t_path_item item);
        t_target_cmd result;
        longint      dx;
        longint      dy;
        longint      sq_dist;
        longint      near_dist;
        int          i;
        int          best;
        int          pick;
        result = '0;
        best = 0;
        near_dist = 0;
        if (item.cmd == CMD_LOAD) begin
            path_store_x[item.index] = item.x;
            path_store_y[item.index] = item.y;
            if (item.last) path_len_now = int'(item.index) + 1;
        end else begin
            if (path_len_now == 0) begin
                result.no_path = 1'b1;
            end else begin
                for (i = 0; i < path_len_now; i++) begin
                    dx = longint'(path_store_x[i]) - longint'(item.x);
                    dy = longint'(path_store_y[i]) - longint'(item.y);
                    sq_dist = dx * dx + dy * dy;
                    if (i == 0 || sq_dist < near_dist) begin  // ties keep the earlier point
                        near_dist = sq_dist;
                        best = i;
                    end
                end
                pick = best + int'(lookahead_now);
                if (pick > path_len_now - 1) pick = path_len_now - 1;
                result.target_x = path_store_x[pick];
                result.target_y = path_store_y[pick];
                result.target_index = IDX_BITS'(pick);
                result.vel_x = VEL_BITS'(scaled_velocity(
                    longint'(path_store_x[pick]) - longint'(item.x)));
                result.vel_y = VEL_BITS'(scaled_velocity(
                    longint'(path_store_y[pick]) - longint'(item.y)));
            end
            expected_commands.push_back(result);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // input side: one transfer per accepted item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) predict_target_command(current_item);
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    current_item = pending_items.pop_front();
                    i_cmd <= current_item.cmd;
                    i_point_index <= current_item.index;
                    i_coord_x <= current_item.x;
                    i_coord_y <= current_item.y;
                    i_last_point <= current_item.last;
                    i_in_valid <= 1'b1;
                    if (idle_pct != 0 && int'($urandom_range(0, 99)) < idle_pct)
                        gap_left = $urandom_range(1, 4);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: compare each transfer, then decide the next stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_commands.size() == 0) begin
                    report_mismatch("unexpected result, target_index",
                                    longint'(o_target_index), 0);
                end else begin
                    next_expected = expected_commands.pop_front();
                    if (o_vel_x !== next_expected.vel_x)
                        report_mismatch("vel_x", longint'(o_vel_x), longint'(next_expected.vel_x));
                    if (o_vel_y !== next_expected.vel_y)
                        report_mismatch("vel_y", longint'(o_vel_y), longint'(next_expected.vel_y));
                    if (o_target_x !== next_expected.target_x)
                        report_mismatch("target_x", longint'(o_target_x),
                                        longint'(next_expected.target_x));
                    if (o_target_y !== next_expected.target_y)
                        report_mismatch("target_y", longint'(o_target_y),
                                        longint'(next_expected.target_y));
                    if (o_target_index !== next_expected.target_index)
                        report_mismatch("target_index", longint'(o_target_index),
                                        longint'(next_expected.target_index));
                    if (o_no_path !== next_expected.no_path)
                        report_mismatch("no_path", longint'(o_no_path),
                                        longint'(next_expected.no_path));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idle_pct != 0 && int'($urandom_range(0, 99)) < idle_pct) begin
                stall_left = $urandom_range(0, 3);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_coord clamp_coord(input longint v);
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return t_coord'(v);
    endfunction

    function automatic t_coord rand_coord(input int style);
        case (style)
            0: return t_coord'($urandom());
            1: return t_coord'(int'($urandom_range(0, 8191)) - 4096);
            default: begin
                case ($urandom_range(0, 4))
                    0: return t_coord'(COORD_MIN);
                    1: return t_coord'(COORD_MAX);
                    2: return t_coord'(0);
                    3: return t_coord'(-1);
                    default: return t_coord'(1);
                endcase
            end
        endcase
    endfunction

    function automatic bit path_queryable();
        int i;
        for (i = 0; i < planned_len; i++)
            if (!loaded[i]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic push_load(input int index, input t_coord x, input t_coord y, input bit last);
        t_path_item item;
        item.cmd = CMD_LOAD;
        item.index = IDX_BITS'(index);
        item.x = x;
        item.y = y;
        item.last = last;
        pending_items.push_back(item);
        loaded[index] = 1'b1;
        plan_x[index] = x;
        plan_y[index] = y;
        if (last) planned_len = index + 1;
        stimulus_items++;
    endtask

    task automatic push_query(input t_coord x, input t_coord y);
        t_path_item item;
        item.cmd = CMD_QUERY;
        item.index = IDX_BITS'($urandom());
        item.x = x;
        item.y = y;
        item.last = 1'($urandom());
        pending_items.push_back(item);
        stimulus_items++;
    endtask

    // style 0: random walk with repeated points, 1: scattered, 2: extremes and duplicates
    task automatic load_path(input int length, input int style, input bit shuffled,
                             input int count);
        t_coord xs [MAX_POINTS];
        t_coord ys [MAX_POINTS];
        int     order [MAX_POINTS];
        int     i;
        int     j;
        int     tmp;
        longint wx;
        longint wy;
        wx = longint'(rand_coord(0));
        wy = longint'(rand_coord(0));
        for (i = 0; i < length; i++) begin
            if (style == 0) begin
                if ($urandom_range(0, 7) != 0) begin
                    wx += int'($urandom_range(0, 256)) - 128;
                    wy += int'($urandom_range(0, 256)) - 128;
                end
                xs[i] = clamp_coord(wx);
                ys[i] = clamp_coord(wy);
                wx = longint'(xs[i]);
                wy = longint'(ys[i]);
            end else if (style == 1) begin
                xs[i] = rand_coord(0);
                ys[i] = rand_coord(0);
            end else if (i > 0 && $urandom_range(0, 2) == 0) begin
                xs[i] = xs[i-1];
                ys[i] = ys[i-1];
            end else begin
                xs[i] = rand_coord(2);
                ys[i] = rand_coord(int'($urandom_range(1, 2)));
            end
            order[i] = i;
        end
        if (shuffled) begin
            for (i = length - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
        end
        for (i = 0; i < count; i++)
            push_load(order[i], xs[order[i]], ys[order[i]], order[i] == length - 1);
    endtask

    task automatic apply_settings(input int look, input int gain);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_LOOKAHEAD;
        i_cfg_data <= CFG_DATA_BITS'(look);
        lookahead_now = LOOK_BITS'(look);
        @(posedge i_clk);
        i_cfg_index <= CFG_SPEED_GAIN;
        i_cfg_data <= CFG_DATA_BITS'(gain);
        gain_now = GAIN_BITS'(gain);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // sampled mid-cycle so the driver's updates of the last edge are visible
    task automatic wait_for_idle();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || o_in_stall || o_out_valid
               || expected_commands.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int     directed_items;
        int     phase_no;
        int     length;
        int     style;
        int     look;
        int     gain;
        int     nq;
        int     q;
        int     k;
        int     idx;
        int     prev_len;
        int     spread;
        longint off_x;
        longint off_y;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty path, extremes, tie between equal points, pose on target
        push_query(t_coord'(COORD_MAX), t_coord'(COORD_MIN));
        push_load(0, t_coord'(COORD_MAX), t_coord'(COORD_MIN), 1'b0);
        push_load(1, t_coord'(COORD_MIN), t_coord'(COORD_MAX), 1'b0);
        push_load(2, t_coord'(0), t_coord'(0), 1'b0);
        push_load(3, t_coord'(0), t_coord'(0), 1'b0);
        push_load(4, t_coord'(100), t_coord'(-100), 1'b1);
        push_query(t_coord'(0), t_coord'(0));
        push_query(t_coord'(COORD_MIN), t_coord'(COORD_MIN));
        push_query(t_coord'(-300), t_coord'(250));
        wait_for_idle();

        // saturation, floor of negative products, lookahead clamped at the end
        apply_settings(255, 65535);
        push_query(t_coord'(COORD_MIN), t_coord'(COORD_MAX));
        push_query(t_coord'(0), t_coord'(0));
        push_load(1, t_coord'(COORD_MIN), t_coord'(COORD_MAX), 1'b1);
        push_query(t_coord'(COORD_MAX), t_coord'(COORD_MIN));
        wait_for_idle();

        apply_settings(1, 0);
        push_query(t_coord'(5), t_coord'(5));
        push_load(255, t_coord'(COORD_MAX), t_coord'(COORD_MAX), 1'b0);
        wait_for_idle();

        apply_settings(0, 1);
        push_load(0, t_coord'(5), t_coord'(-5), 1'b1);
        push_query(t_coord'(6), t_coord'(-4));
        push_query(t_coord'(4), t_coord'(-6));
        push_query(t_coord'(5), t_coord'(-5));
        directed_items = stimulus_items;

        phase_no = 0;
        while (stimulus_items < directed_items + ITEM_TARGET) begin
            wait_for_idle();
            if (stimulus_items > directed_items + ITEM_TARGET - 250) begin
                idle_pct = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    2: idle_pct = 30;
                    default: idle_pct = 60;
                endcase
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 3))
                    0: look = 0;
                    1: look = 255;
                    2: look = $urandom_range(1, 6);
                    default: look = $urandom_range(0, 255);
                endcase
                case ($urandom_range(0, 4))
                    0: gain = 0;
                    1: gain = 65535;
                    2: gain = 256;
                    3: gain = $urandom_range(1, 1023);
                    default: gain = $urandom_range(0, 65535);
                endcase
                apply_settings(look, gain);
            end

            style = $urandom_range(0, 2);
            if (phase_no % 12 == 5)
                length = (phase_no % 24 == 5) ? MAX_POINTS : int'($urandom_range(100, MAX_POINTS));
            else
                length = $urandom_range(1, 24);

            case ($urandom_range(0, 7))
                0: load_path(length, style, 1'($urandom()), int'($urandom_range(0, length - 1)));
                1: begin
                    // stray writes; a last flag only where the path stays fully loaded
                    nq = $urandom_range(1, 8);
                    for (q = 0; q < nq; q++) begin
                        idx = $urandom_range(0, MAX_POINTS - 1);
                        loaded[idx] = 1'b1;
                        push_load(idx, rand_coord(int'($urandom_range(0, 2))),
                                  rand_coord(int'($urandom_range(0, 2))), 1'b0);
                        if ($urandom_range(0, 3) == 0) begin
                            prev_len = planned_len;
                            planned_len = idx + 1;
                            if (path_queryable()) begin
                                pending_items.pop_back();
                                stimulus_items--;
                                push_load(idx, plan_x[idx], plan_y[idx], 1'b1);
                            end else begin
                                planned_len = prev_len;
                            end
                        end
                    end
                end
                default: load_path(length, style, $urandom_range(0, 3) == 0, length);
            endcase

            if (path_queryable()) begin
                nq = $urandom_range(1, 8);
                for (q = 0; q < nq; q++) begin
                    if (planned_len > 0 && $urandom_range(0, 3) != 0) begin
                        k = $urandom_range(0, planned_len - 1);
                        spread = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 400));
                        off_x = longint'($urandom_range(0, 2 * spread)) - spread;
                        off_y = longint'($urandom_range(0, 2 * spread)) - spread;
                        push_query(clamp_coord(longint'(plan_x[k]) + off_x),
                                   clamp_coord(longint'(plan_y[k]) + off_y));
                    end else begin
                        push_query(rand_coord(int'($urandom_range(0, 2))),
                                   rand_coord(int'($urandom_range(0, 2))));
                    end
                end
            end
            phase_no++;
        end

        wait_for_idle();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
